>>> rtl/core/c8i_pkg.sv
// ----------------------------------------------------------------------------
// c8i_pkg
// Shared constants, step codes, command/status types and tables of the
// CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package c8i_pkg;

  localparam int RAM_BYTES_DEF   = 4096;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FONT_BASE_DEF   = 0;

  localparam logic [11:0] PROGRAM_START = 12'h200;
  localparam int DISP_ROWS  = 32;
  localparam int DISP_BYTES = 256;
  localparam int FONT_LEN   = 80;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_WAIT    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_UNDER   = 3'd4;
  localparam logic [2:0] ST_RANGE   = 3'd5;

  // operation codes of an input word
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_EXEC = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // instruction classes after decode
  localparam logic [2:0] CL_SIMPLE  = 3'd0;
  localparam logic [2:0] CL_FLAG    = 3'd1;
  localparam logic [2:0] CL_CLEAR   = 3'd2;
  localparam logic [2:0] CL_DRAW    = 3'd3;
  localparam logic [2:0] CL_BCD     = 3'd4;
  localparam logic [2:0] CL_STORE   = 3'd5;
  localparam logic [2:0] CL_RESTORE = 3'd6;

  // controller states, also the step code seen by the datapath
  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DISP    = 5'd2;
  localparam logic [4:0] S_RDREAD  = 5'd3;
  localparam logic [4:0] S_F1      = 5'd4;
  localparam logic [4:0] S_F2      = 5'd5;
  localparam logic [4:0] S_RDX     = 5'd6;
  localparam logic [4:0] S_RDY     = 5'd7;
  localparam logic [4:0] S_VY      = 5'd8;
  localparam logic [4:0] S_EXEC    = 5'd9;
  localparam logic [4:0] S_VF      = 5'd10;
  localparam logic [4:0] S_CLR_RD  = 5'd11;
  localparam logic [4:0] S_CLR_WR  = 5'd12;
  localparam logic [4:0] S_DR_RD   = 5'd13;
  localparam logic [4:0] S_DR_WR   = 5'd14;
  localparam logic [4:0] S_BCD     = 5'd15;
  localparam logic [4:0] S_ST_RD   = 5'd16;
  localparam logic [4:0] S_ST_WR   = 5'd17;
  localparam logic [4:0] S_LR_RD   = 5'd18;
  localparam logic [4:0] S_LR_WR   = 5'd19;
  localparam logic [4:0] S_COMMIT  = 5'd20;
  localparam logic [4:0] S_DONE    = 5'd21;

  typedef struct packed {
    logic [4:0] step;
    logic       cnt_clr;
    logic       cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       err;
    logic [2:0] cls;
    logic       last;
    logic       none;
    logic       busy;
  } stat_t;

  localparam logic [7:0] FONT_ROM [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // decimal digit of v: sel 0 hundreds, 1 tens, 2 ones (reciprocal multiply)
  function automatic logic [3:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [13:0] ph;
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] pt;
    logic [3:0]  t;
    logic [3:0]  o;
    ph = 14'(v) * 14'd41;
    h  = ph[13:12];
    r  = 7'(v - 8'(h) * 8'd100);
    pt = 15'(r) * 15'd205;
    t  = pt[14:11];
    o  = 4'(r - 7'(t) * 7'd10);
    case (sel)
      2'd0:    bcd_digit = {2'b00, h};
      2'd1:    bcd_digit = t;
      default: bcd_digit = o;
    endcase
  endfunction

endpackage

>>> rtl/core/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 machine with RAM, registers, return stack, frame buffer and timers.
// ----------------------------------------------------------------------------
// Usage: each input word carries one operation (load a RAM byte, execute
// one instruction, tick the timers, read a frame buffer byte) and yields
// exactly one result word with status, program counter, read byte, sound
// and display-changed flags. Words are taken on in_valid with in_stall low
// and delivered on out_valid with out_stall low.
// An instruction is fetched as two RAM bytes, reads its X and Y registers
// and executes; one that sets VF adds a VF write, a clear walks every frame
// buffer row, a draw reads and writes one row per sprite row and then VF,
// a BCD store writes three digits and a register save/restore moves one
// register at a time. Each RAM, register file and frame buffer has one
// write port and one registered read port, which sets this sequence.
// One word is in work at a time; the next word can be taken once the
// previous one lands in the output register, even while that one is stalled.
// Reset: a clearing pass over every RAM address writes the font and zeroes
// RAM, data registers and frame buffer; in_stall stays high meanwhile.
// A stalled result holds its value until taken; a following word that
// finishes meanwhile waits in the final step until the output is free.
// ----------------------------------------------------------------------------
module chip8_instruction_core
  import c8i_pkg::*;
#(
  parameter int RAM_BYTES   = RAM_BYTES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FONT_BASE   = FONT_BASE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_load_data,
  input  logic        in_key_down,
  input  logic [3:0]  in_key_code,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [11:0] out_program_counter,
  output logic [7:0]  out_read_data,
  output logic        out_sound_on,
  output logic        out_display_changed
);

  cmd_t  cmd;   // step and counter control from the sequencer
  stat_t st;    // decode class, error and loop status back to it

  c8i_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  c8i_dp #(
    .RAM_BYTES   (RAM_BYTES),
    .STACK_DEPTH (STACK_DEPTH),
    .FONT_BASE   (FONT_BASE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_valid            (in_valid),
    .in_operation        (in_operation),
    .in_address          (in_address),
    .in_load_data        (in_load_data),
    .in_key_down         (in_key_down),
    .in_key_code         (in_key_code),
    .in_random_byte      (in_random_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_program_counter (out_program_counter),
    .out_read_data       (out_read_data),
    .out_sound_on        (out_sound_on),
    .out_display_changed (out_display_changed)
  );

endmodule

>>> rtl/core/c8i_ctrl.sv
// ----------------------------------------------------------------------------
// c8i_ctrl
// Sequencer of the core: runs the reset clearing pass, walks one word through
// fetch, decode and the multi-cycle memory walks, and hands the result to the output register.
// ----------------------------------------------------------------------------
module c8i_ctrl
  import c8i_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  in_stall
);

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.step    = state_r;
    cmd.cnt_clr = 1'b0;
    cmd.cnt_inc = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.cnt_inc = 1'b1;
        if (st.last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (st.op)
          OP_READ: state_nxt = st.err ? S_DONE : S_RDREAD;
          OP_EXEC: state_nxt = st.err ? S_DONE : S_F1;
          default: state_nxt = S_DONE;
        endcase
      end
      S_RDREAD: state_nxt = S_DONE;
      S_F1:     state_nxt = S_F2;
      S_F2:     state_nxt = S_RDX;
      S_RDX:    state_nxt = S_RDY;
      S_RDY:    state_nxt = S_VY;
      S_VY:     state_nxt = S_EXEC;
      S_EXEC: begin
        cmd.cnt_clr = 1'b1;
        if (st.err) begin
          state_nxt = S_DONE;
        end else begin
          case (st.cls)
            CL_FLAG:    state_nxt = S_VF;
            CL_CLEAR:   state_nxt = S_CLR_RD;
            CL_DRAW:    state_nxt = st.none ? S_VF : S_DR_RD;
            CL_BCD:     state_nxt = S_BCD;
            CL_STORE:   state_nxt = S_ST_RD;
            CL_RESTORE: state_nxt = S_LR_RD;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_VF:     state_nxt = S_COMMIT;
      S_CLR_RD: state_nxt = S_CLR_WR;
      S_CLR_WR: begin
        cmd.cnt_inc = 1'b1;
        state_nxt   = st.last ? S_COMMIT : S_CLR_RD;
      end
      S_DR_RD:  state_nxt = S_DR_WR;
      S_DR_WR: begin
        cmd.cnt_inc = 1'b1;
        state_nxt   = st.last ? S_VF : S_DR_RD;
      end
      S_BCD: begin
        cmd.cnt_inc = 1'b1;
        state_nxt   = st.last ? S_COMMIT : S_BCD;
      end
      S_ST_RD:  state_nxt = S_ST_WR;
      S_ST_WR: begin
        cmd.cnt_inc = 1'b1;
        state_nxt   = st.last ? S_COMMIT : S_ST_RD;
      end
      S_LR_RD:  state_nxt = S_LR_WR;
      S_LR_WR: begin
        cmd.cnt_inc = 1'b1;
        state_nxt   = st.last ? S_COMMIT : S_LR_RD;
      end
      S_COMMIT: state_nxt = S_DONE;
      S_DONE: begin
        if (!st.busy) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_INIT;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> rtl/core/c8i_dp.sv
// ----------------------------------------------------------------------------
// c8i_dp
// Datapath: RAM, data registers, return stack, frame buffer, machine
// registers, instruction decode and the output register.
// ----------------------------------------------------------------------------
module c8i_dp
  import c8i_pkg::*;
#(
  parameter int RAM_BYTES   = RAM_BYTES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FONT_BASE   = FONT_BASE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic        in_valid,
  input  logic [1:0]  in_operation,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_load_data,
  input  logic        in_key_down,
  input  logic [3:0]  in_key_code,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [11:0] out_program_counter,
  output logic [7:0]  out_read_data,
  output logic        out_sound_on,
  output logic        out_display_changed
);

  localparam int RW = $clog2(RAM_BYTES);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam logic [12:0]   RAM_LIM = 13'(RAM_BYTES);
  localparam logic [SW:0]   STK_LIM = (SW+1)'(STACK_DEPTH);
  localparam logic [RW-1:0] FONT_LO = RW'(FONT_BASE);
  localparam logic [RW:0]   FONT_HI = (RW+1)'(FONT_BASE + FONT_LEN);
  localparam logic [RW-1:0] CNT_END = RW'(RAM_BYTES - 1);

  // instruction groups and sub-codes
  localparam logic [3:0]  G_SYS = 4'h0, G_JP = 4'h1, G_CALL = 4'h2, G_SEB = 4'h3;
  localparam logic [3:0]  G_SNEB = 4'h4, G_SER = 4'h5, G_LDB = 4'h6, G_ADDB = 4'h7;
  localparam logic [3:0]  G_ALU = 4'h8, G_SNER = 4'h9, G_LDI = 4'hA, G_JPV = 4'hB;
  localparam logic [3:0]  G_RND = 4'hC, G_DRW = 4'hD, G_KEY = 4'hE;
  localparam logic [15:0] OPC_CLS = 16'h00E0, OPC_RET = 16'h00EE;
  localparam logic [3:0]  A_MOV = 4'h0, A_OR = 4'h1, A_AND = 4'h2, A_XOR = 4'h3;
  localparam logic [3:0]  A_ADD = 4'h4, A_SUB = 4'h5, A_SHR = 4'h6, A_SUBN = 4'h7;
  localparam logic [3:0]  A_SHL = 4'hE;
  localparam logic [7:0]  K_SKP = 8'h9E, K_SKNP = 8'hA1;
  localparam logic [7:0]  F_GDT = 8'h07, F_KEY = 8'h0A, F_SDT = 8'h15, F_SST = 8'h18;
  localparam logic [7:0]  F_ADI = 8'h1E, F_FNT = 8'h29, F_BCD = 8'h33;
  localparam logic [7:0]  F_STR = 8'h55, F_RST = 8'h65;
  localparam logic [3:0]  V_FLAG = 4'hF;

  // storage
  logic [7:0]  ram_mem [RAM_BYTES];
  logic [7:0]  v_mem [16];
  logic [11:0] stk_mem [STACK_DEPTH];
  logic [63:0] fb_mem [DISP_ROWS];

  logic [7:0]    ram_q, ram_wdata;
  logic [RW-1:0] ram_waddr, ram_raddr;
  logic          ram_we;
  logic [7:0]    v_q, v_wdata;
  logic [3:0]    v_waddr, v_raddr;
  logic          v_we;
  logic [11:0]   stk_q;
  logic [SW-1:0] stk_raddr;
  logic          stk_we;
  logic [63:0]   fb_q, fb_wdata;
  logic [4:0]    fb_waddr, fb_raddr;
  logic          fb_we;

  // machine and work registers
  logic [11:0]   pc_r, i_r, npc_r, addr_r, ins_lo_unused;
  logic [SW:0]   sp_r;
  logic [7:0]    dt_r, snd_r, vx_r, vy_r, ldata_r, rnd_r, rdata_r;
  logic [15:0]   ins_r;
  logic [1:0]    op_r;
  logic          kdown_r, flag_r, chg_r;
  logic [3:0]    kcode_r;
  logic [2:0]    stat_r;
  logic [RW-1:0] cnt_r;
  logic          out_valid_r, out_sound_r, out_chg_r;
  logic [2:0]    out_status_r;
  logic [11:0]   out_pc_r;
  logic [7:0]    out_rdata_r;

  assign ins_lo_unused = 12'h0;

  logic [3:0]  nib, xi, yi, ni;
  logic [7:0]  kk;
  logic [11:0] nnn, pc_adv, pc_skip, pc1, iaddr12;
  logic [SW:0] spm1;
  logic [8:0]  sum9;
  logic [4:0]  row;
  logic [63:0] spr, rot;
  logic [127:0] spr2;
  logic        hit, accept, emit;

  assign nib     = ins_r[15:12];
  assign xi      = ins_r[11:8];
  assign yi      = ins_r[7:4];
  assign ni      = ins_r[3:0];
  assign kk      = ins_r[7:0];
  assign nnn     = ins_r[11:0];
  assign pc_adv  = pc_r + 12'd2;
  assign pc_skip = pc_r + 12'd4;
  assign pc1     = pc_r + 12'd1;
  assign iaddr12 = i_r + 12'(cnt_r);
  assign spm1    = sp_r - 1'b1;
  assign sum9    = {1'b0, vx_r} + {1'b0, vy_r};
  assign row     = vy_r[4:0] + cnt_r[4:0];
  assign spr     = {ram_q, 56'h0};
  assign spr2    = {spr, spr} >> vx_r[5:0];
  assign rot     = spr2[63:0];
  assign hit     = kdown_r && ({4'h0, kcode_r} == vx_r);
  assign accept  = (cmd.step == S_IDLE) && in_valid;
  assign emit    = (cmd.step == S_DONE) && !st.busy;

  // operation-level range checks
  logic [2:0] d_err;
  always_comb begin
    d_err = ST_OK;
    case (op_r)
      OP_LOAD: if ({1'b0, addr_r} >= RAM_LIM) d_err = ST_RANGE;
      OP_READ: if ({1'b0, addr_r} >= 13'(DISP_BYTES)) d_err = ST_RANGE;
      OP_EXEC: if ({1'b0, pc_r} >= RAM_LIM - 13'd1) d_err = ST_RANGE;
      default: d_err = ST_OK;
    endcase
  end

  // instruction decode and the effects applied in the execute step
  logic [2:0]  x_err, x_cls;
  logic        x_vwe, x_flag, x_iwe, x_push, x_pop, x_dtwe, x_stwe;
  logic [7:0]  x_vdata;
  logic [11:0] x_pc, x_i;

  always_comb begin
    x_err = ST_OK; x_cls = CL_SIMPLE; x_vwe = 1'b0; x_vdata = 8'h0; x_flag = 1'b0;
    x_pc = pc_adv; x_iwe = 1'b0; x_i = i_r; x_push = 1'b0; x_pop = 1'b0;
    x_dtwe = 1'b0; x_stwe = 1'b0;
    case (nib)
      G_SYS: begin
        if (ins_r == OPC_CLS) begin
          x_cls = CL_CLEAR;
        end else if (ins_r == OPC_RET) begin
          if (sp_r == '0) x_err = ST_UNDER;
          else begin
            x_pop = 1'b1;
            x_pc  = stk_q + 12'd2;
          end
        end
      end
      G_JP: x_pc = nnn;
      G_CALL: begin
        if (sp_r >= STK_LIM) x_err = ST_OVER;
        else begin
          x_push = 1'b1;
          x_pc   = nnn;
        end
      end
      G_SEB:  if (vx_r == kk) x_pc = pc_skip;
      G_SNEB: if (vx_r != kk) x_pc = pc_skip;
      G_SER: begin
        if (ni != 4'h0) x_err = ST_UNKNOWN;
        else if (vx_r == vy_r) x_pc = pc_skip;
      end
      G_LDB: begin
        x_vwe = 1'b1; x_vdata = kk;
      end
      G_ADDB: begin
        x_vwe = 1'b1; x_vdata = vx_r + kk;
      end
      G_ALU: begin
        x_vwe = 1'b1;
        case (ni)
          A_MOV: x_vdata = vy_r;
          A_OR:  x_vdata = vx_r | vy_r;
          A_AND: x_vdata = vx_r & vy_r;
          A_XOR: x_vdata = vx_r ^ vy_r;
          A_ADD: begin
            x_vdata = sum9[7:0]; x_flag = sum9[8]; x_cls = CL_FLAG;
          end
          A_SUB: begin
            x_vdata = vx_r - vy_r; x_flag = (vx_r >= vy_r); x_cls = CL_FLAG;
          end
          A_SHR: begin
            x_vdata = {1'b0, vx_r[7:1]}; x_flag = vx_r[0]; x_cls = CL_FLAG;
          end
          A_SUBN: begin
            x_vdata = vy_r - vx_r; x_flag = (vy_r >= vx_r); x_cls = CL_FLAG;
          end
          A_SHL: begin
            x_vdata = {vx_r[6:0], 1'b0}; x_flag = vx_r[7]; x_cls = CL_FLAG;
          end
          default: begin
            x_vwe = 1'b0; x_err = ST_UNKNOWN;
          end
        endcase
      end
      G_SNER: begin
        if (ni != 4'h0) x_err = ST_UNKNOWN;
        else if (vx_r != vy_r) x_pc = pc_skip;
      end
      G_LDI: begin
        x_iwe = 1'b1; x_i = nnn;
      end
      G_JPV: x_pc = nnn + {4'h0, vx_r};
      G_RND: begin
        x_vwe = 1'b1; x_vdata = rnd_r & kk;
      end
      G_DRW: begin
        if ({1'b0, i_r} + 13'(ni) > RAM_LIM) x_err = ST_RANGE;
        else x_cls = CL_DRAW;
      end
      G_KEY: begin
        case (kk)
          K_SKP:   if (hit) x_pc = pc_skip;
          K_SKNP:  if (!hit) x_pc = pc_skip;
          default: x_err = ST_UNKNOWN;
        endcase
      end
      default: begin
        case (kk)
          F_GDT: begin
            x_vwe = 1'b1; x_vdata = dt_r;
          end
          F_KEY: begin
            if (!kdown_r) x_err = ST_WAIT;
            else begin
              x_vwe = 1'b1; x_vdata = {4'h0, kcode_r};
            end
          end
          F_SDT: x_dtwe = 1'b1;
          F_SST: x_stwe = 1'b1;
          F_ADI: begin
            x_iwe = 1'b1; x_i = i_r + {4'h0, vx_r};
          end
          F_FNT: begin
            x_iwe = 1'b1;
            x_i   = 12'(FONT_BASE) + {6'h0, vx_r[3:0], 2'b00} + {8'h0, vx_r[3:0]};
          end
          F_BCD: begin
            if ({1'b0, i_r} + 13'd3 > RAM_LIM) x_err = ST_RANGE;
            else x_cls = CL_BCD;
          end
          F_STR: begin
            if ({1'b0, i_r} + 13'(xi) + 13'd1 > RAM_LIM) x_err = ST_RANGE;
            else x_cls = CL_STORE;
          end
          F_RST: begin
            if ({1'b0, i_r} + 13'(xi) + 13'd1 > RAM_LIM) x_err = ST_RANGE;
            else x_cls = CL_RESTORE;
          end
          default: x_err = ST_UNKNOWN;
        endcase
      end
    endcase
  end

  // status to the controller
  always_comb begin
    st.op   = op_r;
    st.cls  = x_cls;
    st.none = (ni == 4'h0);
    st.busy = out_valid_r && out_stall;
    st.err  = (cmd.step == S_DISP) ? (d_err != ST_OK) : (x_err != ST_OK);
    case (cmd.step)
      S_INIT:               st.last = (cnt_r == CNT_END);
      S_CLR_WR:             st.last = (cnt_r == RW'(DISP_ROWS - 1));
      S_DR_WR:              st.last = (cnt_r + 1'b1 == RW'(ni));
      S_BCD:                st.last = (cnt_r == RW'(2));
      S_ST_WR, S_LR_WR:     st.last = (cnt_r == RW'(xi));
      default:              st.last = 1'b0;
    endcase
  end

  // memory port selection
  logic [RW-1:0] fofs;
  logic          in_font;
  assign fofs    = cnt_r - FONT_LO;
  assign in_font = (cnt_r >= FONT_LO) && ({1'b0, cnt_r} < FONT_HI);

  always_comb begin
    ram_we = 1'b0; ram_waddr = iaddr12[RW-1:0]; ram_wdata = 8'h0;
    ram_raddr = iaddr12[RW-1:0];
    v_we = 1'b0; v_waddr = xi; v_wdata = x_vdata; v_raddr = yi;
    stk_we = 1'b0;
    stk_raddr = (sp_r == '0) ? '0 : spm1[SW-1:0];
    fb_we = 1'b0; fb_waddr = row; fb_wdata = 64'h0; fb_raddr = row;
    case (cmd.step)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = in_font ? FONT_ROM[fofs[6:0]] : 8'h0;
        v_we      = (cnt_r < RW'(16));
        v_waddr   = cnt_r[3:0];
        v_wdata   = 8'h0;
        fb_we     = (cnt_r < RW'(DISP_ROWS));
        fb_waddr  = cnt_r[4:0];
      end
      S_DISP: begin
        ram_we    = (op_r == OP_LOAD) && (d_err == ST_OK);
        ram_waddr = addr_r[RW-1:0];
        ram_wdata = ldata_r;
        ram_raddr = pc_r[RW-1:0];
        fb_raddr  = addr_r[7:3];
      end
      S_F1:  ram_raddr = pc1[RW-1:0];
      S_RDX: v_raddr = (nib == G_JPV) ? 4'h0 : xi;
      S_EXEC: begin
        v_we   = x_vwe && (x_err == ST_OK);
        stk_we = x_push && (x_err == ST_OK);
      end
      S_VF: begin
        v_we = 1'b1; v_waddr = V_FLAG; v_wdata = {7'h0, flag_r};
      end
      S_CLR_RD: fb_raddr = cnt_r[4:0];
      S_CLR_WR: begin
        fb_we = 1'b1; fb_waddr = cnt_r[4:0];
      end
      S_DR_WR: begin
        fb_we = 1'b1; fb_wdata = fb_q ^ rot;
      end
      S_BCD: begin
        ram_we = 1'b1; ram_wdata = {4'h0, bcd_digit(vx_r, cnt_r[1:0])};
      end
      S_ST_RD: v_raddr = cnt_r[3:0];
      S_ST_WR: begin
        ram_we = 1'b1; ram_wdata = v_q;
      end
      S_LR_WR: begin
        v_we = 1'b1; v_waddr = cnt_r[3:0]; v_wdata = ram_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_we) ram_mem[ram_waddr] <= ram_wdata;
    ram_q <= ram_mem[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) v_mem[v_waddr] <= v_wdata;
    v_q <= v_mem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[sp_r[SW-1:0]] <= pc_r;
    stk_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
    fb_q <= fb_mem[fb_raddr];
  end

  // architectural and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PROGRAM_START;
      i_r         <= 12'h0;
      sp_r        <= '0;
      dt_r        <= 8'h0;
      snd_r       <= 8'h0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr)      cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;

      if (emit)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      case (cmd.step)
        S_DISP: begin
          if (op_r == OP_TICK) begin
            if (dt_r != 8'h0)  dt_r  <= dt_r - 8'd1;
            if (snd_r != 8'h0) snd_r <= snd_r - 8'd1;
          end
        end
        S_EXEC: begin
          if (x_err == ST_OK) begin
            if (x_cls == CL_SIMPLE) pc_r <= x_pc;
            if (x_iwe)  i_r   <= x_i;
            if (x_push) sp_r  <= sp_r + 1'b1;
            if (x_pop)  sp_r  <= spm1;
            if (x_dtwe) dt_r  <= vx_r;
            if (x_stwe) snd_r <= vx_r;
          end
        end
        S_COMMIT: pc_r <= npc_r;
        default:  pc_r <= pc_r;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      addr_r  <= in_address;
      ldata_r <= in_load_data;
      kdown_r <= in_key_down;
      kcode_r <= in_key_code;
      rnd_r   <= in_random_byte;
      stat_r  <= ST_OK;
      chg_r   <= 1'b0;
      rdata_r <= 8'h0;
    end
    case (cmd.step)
      S_DISP:   if (d_err != ST_OK) stat_r <= d_err;
      S_RDREAD: rdata_r <= fb_q[{~addr_r[2:0], 3'b000} +: 8];
      S_F1:     ins_r[15:8] <= ram_q;
      S_F2:     ins_r[7:0] <= ram_q;
      S_RDY:    vx_r <= v_q;
      S_VY:     vy_r <= v_q;
      S_EXEC: begin
        stat_r <= x_err;
        flag_r <= x_flag;
        npc_r  <= pc_adv | ins_lo_unused;
      end
      S_CLR_WR: if (fb_q != 64'h0) chg_r <= 1'b1;
      S_DR_WR: begin
        if ((fb_q & rot) != 64'h0) flag_r <= 1'b1;
        if (rot != 64'h0) chg_r <= 1'b1;
      end
      default:  flag_r <= flag_r;
    endcase
    if (emit) begin
      out_status_r <= stat_r;
      out_pc_r     <= pc_r;
      out_rdata_r  <= rdata_r;
      out_sound_r  <= (snd_r != 8'h0);
      out_chg_r    <= chg_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_program_counter = out_pc_r;
  assign out_read_data       = out_rdata_r;
  assign out_sound_on        = out_sound_r;
  assign out_display_changed = out_chg_r;

endmodule

>>> rtl/core/c8i_chk.sv
// ----------------------------------------------------------------------------
// c8i_chk
// Port-level checks of the CHIP-8 instruction core, bound to the top level.
// ----------------------------------------------------------------------------
module c8i_chk
  import c8i_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [11:0] out_program_counter,
  input logic [7:0]  out_read_data,
  input logic        out_display_changed
);

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("word taken back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_program_counter) && $stable(out_read_data))
    else $error("stalled result word changed");

  a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_display_changed)
    else $error("display change reported with non-ok status");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != 8'h0 |-> out_status == ST_OK)
    else $error("read byte with failing status");

endmodule

bind chip8_instruction_core c8i_chk u_c8i_chk (.*);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CHIP-8 instruction core. A behavioral machine
// model predicts one result word per input word. A directed table runs
// first, then random programs are built in RAM and executed, mixed with
// timer ticks, frame buffer reads and stray loads. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import c8i_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_WORDS   = 550;

  typedef struct packed {
    logic [2:0]  st;
    logic [11:0] pcv;
    logic [7:0]  rd;
    logic        snd;
    logic        chg;
  } result_t;

  // one row of the directed table; exec rows carry an opcode that the
  // loop first loads at the predicted PC
  typedef struct {
    logic [1:0]  op;
    logic [11:0] addr;
    logic [15:0] data;
    logic        kd;
    logic [3:0]  kc;
    logic [7:0]  rb;
    bit          typed;
    result_t     res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_TICK;
  logic [11:0] in_address = '0;
  logic [7:0]  in_load_data = '0;
  logic        in_key_down = 1'b0;
  logic [3:0]  in_key_code = '0;
  logic [7:0]  in_random_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [11:0] out_program_counter;
  logic [7:0]  out_read_data;
  logic        out_sound_on;
  logic        out_display_changed;

  chip8_instruction_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_address          (in_address),
    .in_load_data        (in_load_data),
    .in_key_down         (in_key_down),
    .in_key_code         (in_key_code),
    .in_random_byte      (in_random_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_program_counter (out_program_counter),
    .out_read_data       (out_read_data),
    .out_sound_on        (out_sound_on),
    .out_display_changed (out_display_changed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Machine model state
  // --------------------------------------------------------------------------
  logic [7:0]  m_ram [RAM_BYTES_DEF];
  logic [7:0]  m_v [16];
  logic [11:0] m_i;
  logic [11:0] m_pc;
  logic [11:0] m_stack [16];
  int unsigned m_sp;
  logic [63:0] m_fb [DISP_ROWS];
  logic [7:0]  m_dt;
  logic [7:0]  m_st;

  result_t pending_results[$];
  int      errors = 0;
  int      hold_ask = 0;
  int      hold_seen = 0;

  function automatic void machine_reset();
    for (int a = 0; a < RAM_BYTES_DEF; a++) m_ram[a] = 8'h00;
    for (int a = 0; a < FONT_LEN; a++) m_ram[FONT_BASE_DEF + a] = FONT_ROM[a];
    for (int r = 0; r < 16; r++) begin
      m_v[r] = 8'h00;
      m_stack[r] = 12'h000;
    end
    for (int r = 0; r < DISP_ROWS; r++) m_fb[r] = 64'h0;
    m_i = 12'h000;
    m_pc = PROGRAM_START;
    m_sp = 0;
    m_dt = 8'h00;
    m_st = 8'h00;
  endfunction

  // Execute one instruction on the model; state changes only on OK.
  function automatic logic [2:0] machine_exec(input logic kd, input logic [3:0] kc,
                                              input logic [7:0] rb, output logic chg);
    logic [15:0] opc;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn, nxt;
    logic [63:0] s, msk;
    int unsigned col, row, collide;
    logic [8:0]  sum;
    bit          hit;
    chg = 1'b0;
    if (m_pc >= 12'(RAM_BYTES_DEF - 1)) return ST_RANGE;
    opc = {m_ram[m_pc], m_ram[m_pc + 12'd1]};
    x = opc[11:8];
    y = opc[7:4];
    n = opc[3:0];
    kk = opc[7:0];
    nnn = opc[11:0];
    vx = m_v[x];
    vy = m_v[y];
    nxt = m_pc + 12'd2;
    case (opc[15:12])
      4'h0: begin
        if (opc == 16'h00E0) begin
          for (int r = 0; r < DISP_ROWS; r++) begin
            if (m_fb[r] != 0) chg = 1'b1;
            m_fb[r] = 64'h0;
          end
        end else if (opc == 16'h00EE) begin
          if (m_sp == 0) return ST_UNDER;
          m_sp--;
          nxt = m_stack[m_sp[3:0]] + 12'd2;
        end
      end
      4'h1: nxt = nnn;
      4'h2: begin
        if (m_sp >= STACK_DEPTH_DEF) return ST_OVER;
        m_stack[m_sp[3:0]] = m_pc;
        m_sp++;
        nxt = nnn;
      end
      4'h3: if (vx == kk) nxt = nxt + 12'd2;
      4'h4: if (vx != kk) nxt = nxt + 12'd2;
      4'h5: begin
        if (n != 0) return ST_UNKNOWN;
        if (vx == vy) nxt = nxt + 12'd2;
      end
      4'h6: m_v[x] = kk;
      4'h7: m_v[x] = vx + kk;
      4'h8: begin
        case (n)
          4'h0: m_v[x] = vy;
          4'h1: m_v[x] = vx | vy;
          4'h2: m_v[x] = vx & vy;
          4'h3: m_v[x] = vx ^ vy;
          4'h4: begin
            sum = {1'b0, vx} + {1'b0, vy};
            m_v[x] = sum[7:0];
            m_v[15] = {7'd0, sum[8]};
          end
          4'h5: begin
            m_v[x] = vx - vy;
            m_v[15] = {7'd0, vx >= vy};
          end
          4'h6: begin
            m_v[x] = vx >> 1;
            m_v[15] = {7'd0, vx[0]};
          end
          4'h7: begin
            m_v[x] = vy - vx;
            m_v[15] = {7'd0, vy >= vx};
          end
          4'hE: begin
            m_v[x] = vx << 1;
            m_v[15] = {7'd0, vx[7]};
          end
          default: return ST_UNKNOWN;
        endcase
      end
      4'h9: begin
        if (n != 0) return ST_UNKNOWN;
        if (vx != vy) nxt = nxt + 12'd2;
      end
      4'hA: m_i = nnn;
      4'hB: nxt = nnn + {4'h0, m_v[0]};
      4'hC: m_v[x] = rb & kk;
      4'hD: begin
        if (int'(m_i) + int'(n) > RAM_BYTES_DEF) return ST_RANGE;
        col = vx % 64;
        collide = 0;
        for (int k = 0; k < n; k++) begin
          s = {m_ram[m_i + 12'(k)], 56'h0};
          msk = (col == 0) ? s : ((s >> col) | (s << (64 - col)));
          row = (int'(vy) + k) % DISP_ROWS;
          if ((m_fb[row] & msk) != 0) collide = 1;
          if (msk != 0) chg = 1'b1;
          m_fb[row] ^= msk;
        end
        m_v[15] = 8'(collide);
      end
      4'hE: begin
        hit = kd && (kc == vx[3:0]) && (vx[7:4] == 4'h0);
        if (kk == 8'h9E) begin
          if (hit) nxt = nxt + 12'd2;
        end else if (kk == 8'hA1) begin
          if (!hit) nxt = nxt + 12'd2;
        end else begin
          return ST_UNKNOWN;
        end
      end
      default: begin
        case (kk)
          8'h07: m_v[x] = m_dt;
          8'h0A: begin
            if (!kd) return ST_WAIT;
            m_v[x] = {4'h0, kc};
          end
          8'h15: m_dt = vx;
          8'h18: m_st = vx;
          8'h1E: m_i = m_i + {4'h0, vx};
          8'h29: m_i = 12'(FONT_BASE_DEF) + 12'd5 * {8'h0, vx[3:0]};
          8'h33: begin
            if (int'(m_i) + 3 > RAM_BYTES_DEF) return ST_RANGE;
            m_ram[m_i]         = vx / 100;
            m_ram[m_i + 12'd1] = (vx / 10) % 10;
            m_ram[m_i + 12'd2] = vx % 10;
          end
          8'h55: begin
            if (int'(m_i) + int'(x) + 1 > RAM_BYTES_DEF) return ST_RANGE;
            for (int k = 0; k <= x; k++) m_ram[m_i + 12'(k)] = m_v[k];
          end
          8'h65: begin
            if (int'(m_i) + int'(x) + 1 > RAM_BYTES_DEF) return ST_RANGE;
            for (int k = 0; k <= x; k++) m_v[k] = m_ram[m_i + 12'(k)];
          end
          default: return ST_UNKNOWN;
        endcase
      end
    endcase
    m_pc = nxt;
    return ST_OK;
  endfunction

  function automatic result_t machine_step(input logic [1:0] op, input logic [11:0] addr,
                                           input logic [7:0] data, input logic kd,
                                           input logic [3:0] kc, input logic [7:0] rb);
    result_t r;
    logic    chg;
    r = '0;
    case (op)
      OP_LOAD: m_ram[addr] = data;
      OP_EXEC: begin
        r.st = machine_exec(kd, kc, rb, chg);
        r.chg = (r.st == ST_OK || r.st == ST_WAIT) ? chg : 1'b0;
      end
      OP_TICK: begin
        if (m_dt != 0) m_dt--;
        if (m_st != 0) m_st--;
      end
      default: begin
        if (addr < DISP_BYTES) r.rd = m_fb[addr / 8] >> (56 - 8 * (addr % 8));
        else r.st = ST_RANGE;
      end
    endcase
    r.pcv = m_pc;
    r.snd = (m_st != 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps
  // --------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_word(input logic [1:0] op, input logic [11:0] addr,
                           input logic [7:0] data, input logic kd, input logic [3:0] kc,
                           input logic [7:0] rb, input bit typed, input result_t typed_res);
    result_t pred;
    int      gap;
    pred = machine_step(op, addr, data, kd, kc, rb);
    pending_results.push_back(typed ? typed_res : pred);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_address     <= addr;
    in_load_data   <= data;
    in_key_down    <= kd;
    in_key_code    <= kc;
    in_random_byte <= rb;
    do @(posedge clk); while (in_stall);
    // close the burst and, unless the random gap is zero, idle before the next one
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_plain(input logic [1:0] op, input logic [11:0] addr,
                            input logic [7:0] data, input logic kd, input logic [3:0] kc,
                            input logic [7:0] rb);
    send_word(op, addr, data, kd, kc, rb, 1'b0, '0);
  endtask

  // load an opcode at the predicted PC and execute it
  task automatic run_opcode(input logic [15:0] opc, input logic kd, input logic [3:0] kc,
                            input logic [7:0] rb, input bit typed, input result_t res);
    if (m_pc < 12'hFFF) begin
      send_plain(OP_LOAD, m_pc, opc[15:8], $urandom, $urandom, $urandom);
      send_plain(OP_LOAD, m_pc + 12'd1, opc[7:0], $urandom, $urandom, $urandom);
    end
    send_word(OP_EXEC, $urandom, $urandom, kd, kc, rb, typed, res);
  endtask

  // pick an instruction that mostly keeps the program alive
  function automatic logic [15:0] pick_opcode();
    logic [15:0] opc;
    logic [11:0] tgt;
    logic [7:0]  fsel [10] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55,
                               8'h65, 8'h00};
    tgt = 12'($urandom_range(12'h200, 12'hEF0));
    opc = 16'($urandom);
    if (m_pc >= 12'hF00) return {4'h1, tgt};
    case (opc[15:12])
      4'h0: begin
        case ($urandom_range(0, 3))
          0: opc = 16'h00E0;
          1, 2: opc = 16'h00EE;
          default: opc = {4'h0, 12'($urandom)};
        endcase
      end
      4'h1, 4'h2: opc[11:0] = tgt;
      4'hB: opc[11:0] = tgt - 12'h100;
      4'hA: if ($urandom_range(0, 3) == 0) opc[11:0] = 12'($urandom_range(12'hFF0, 12'hFFF));
      4'hD: opc[3:0] = 4'($urandom_range(0, 8));
      4'h8: if ($urandom_range(0, 5) != 0) opc[3:0] = ($urandom_range(0, 1)) ? 4'hE
                                                       : 4'($urandom_range(0, 7));
      4'h5, 4'h9: if ($urandom_range(0, 4) != 0) opc[3:0] = 4'h0;
      4'hE: if ($urandom_range(0, 5) != 0) opc[7:0] = ($urandom_range(0, 1)) ? 8'h9E : 8'hA1;
      4'hF: if ($urandom_range(0, 7) != 0) opc[7:0] = fsel[$urandom_range(0, 8)];
      default: ;
    endcase
    return opc;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus one long hold-off on request
  // --------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(16, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (mode_left % 5 < 2);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.st)
          report($sformatf("status %0d, want %0d", out_status, want.st));
        if (out_program_counter !== want.pcv)
          report($sformatf("pc %h, want %h", out_program_counter, want.pcv));
        if (out_read_data !== want.rd)
          report($sformatf("read_data %h, want %h", out_read_data, want.rd));
        if (out_sound_on !== want.snd)
          report($sformatf("sound_on %b, want %b", out_sound_on, want.snd));
        if (out_display_changed !== want.chg)
          report($sformatf("display_changed %b, want %b", out_display_changed, want.chg));
      end
    end
  end

  // watchdog on cycles where neither channel moves a word
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic row_t mk(input logic [1:0] op, input logic [11:0] addr,
                              input logic [15:0] data, input logic kd, input logic [3:0] kc,
                              input logic [7:0] rb, input bit typed, input logic [2:0] st,
                              input logic [11:0] pcv);
    row_t r;
    r.op = op; r.addr = addr; r.data = data; r.kd = kd; r.kc = kc; r.rb = rb;
    r.typed = typed;
    r.res = '{st: st, pcv: pcv, rd: 8'h00, snd: 1'b0, chg: 1'b0};
    return r;
  endfunction

  initial begin
    row_t      rows[$];
    logic [1:0] nop;
    int        rnd;
    machine_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, read range edges, key wait, errors, simple, flag, clear and draw classes
    rows.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 1, ST_OK, PROGRAM_START));
    rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 1, ST_OK, PROGRAM_START));
    rows.push_back(mk(OP_READ, 255, 0, 1, 4'hF, 8'hFF, 1, ST_OK, PROGRAM_START));
    rows.push_back(mk(OP_READ, 256, 0, 0, 0, 0, 1, ST_RANGE, PROGRAM_START));
    rows.push_back(mk(OP_READ, 12'hFFF, 0, 0, 0, 0, 1, ST_RANGE, PROGRAM_START));
    rows.push_back(mk(OP_EXEC, 0, 16'h00EE, 0, 0, 0, 1, ST_UNDER, PROGRAM_START));
    rows.push_back(mk(OP_EXEC, 0, 16'h8AB8, 0, 0, 0, 1, ST_UNKNOWN, PROGRAM_START));
    rows.push_back(mk(OP_EXEC, 0, 16'hF00A, 0, 0, 0, 1, ST_WAIT, PROGRAM_START));
    rows.push_back(mk(OP_EXEC, 0, 16'h0000, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'h6A3E, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'hF129, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'hDAB5, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'hDAB5, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'hDAB0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'hF30A, 1, 4'h0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'hE39E, 1, 4'h0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'h6FFF, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'h8FF4, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'hCAFF, 0, 0, 8'hA5, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'hFA18, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'hAFFE, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'hFA33, 0, 0, 0, 1, ST_RANGE, 12'h000));
    rows.push_back(mk(OP_EXEC, 0, 16'h00E0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_EXEC, 0, 16'hB300, 0, 0, 0, 0, 0, 0));

    burst_left = $urandom_range(1, 40);
    foreach (rows[k]) begin
      if (rows[k].op == OP_EXEC) begin
        // range row: pc is only known once the rows ahead of it are predicted
        if (rows[k].typed && rows[k].res.pcv == 12'h000) rows[k].res.pcv = m_pc;
        if (rows[k].typed) rows[k].res.snd = (m_st != 0);
        run_opcode(rows[k].data, rows[k].kd, rows[k].kc, rows[k].rb,
                   rows[k].typed, rows[k].res);
      end else begin
        send_word(rows[k].op, rows[k].addr, rows[k].data[7:0], rows[k].kd, rows[k].kc,
                  rows[k].rb, rows[k].typed, rows[k].res);
      end
    end

    // fill the return stack past its depth, then unwind it
    repeat (STACK_DEPTH_DEF + 1) run_opcode({4'h2, m_pc + 12'd2}, 0, 0, 0, 0, '0);
    repeat (STACK_DEPTH_DEF) run_opcode(16'h00EE, 0, 0, 0, 0, '0);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      // hold the receiver off once, and once drain everything mid-run
      if (k == RANDOM_WORDS / 3) hold_ask++;
      if (k == 2 * RANDOM_WORDS / 3 && pending_results.size() != 0) begin
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
      end
      rnd = $urandom_range(0, 99);
      if (rnd < 75) begin
        run_opcode(pick_opcode(), $urandom, $urandom, $urandom, 0, '0);
      end else begin
        nop = (rnd < 83) ? OP_TICK : (rnd < 93) ? OP_READ : OP_LOAD;
        send_plain(nop, (nop == OP_READ && rnd[0]) ? 12'($urandom_range(0, 300)) : $urandom,
                   $urandom, $urandom, $urandom, $urandom);
      end
    end

    // fetch beyond the end of RAM; the core stays stuck here, so it goes last
    run_opcode(16'h1FFF, 0, 0, 0, 0, '0);
    send_plain(OP_EXEC, 0, 0, 0, 0, 0);

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/c8i_pkg.sv
rtl/core/c8i_ctrl.sv
rtl/core/c8i_dp.sv
rtl/core/chip8_instruction_core.sv
rtl/core/c8i_chk.sv
tb/tb_top.sv
